FILE: rtl/pcgbi_pkg.sv
package pcgbi_pkg;

    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 64;

    // register index, decoded from paddr[3]
    localparam logic REG_SEED = 1'b0;

    localparam logic [63:0] PCG_MUL    = 64'd6364136223846793005;
    localparam logic [63:0] PCG_INC    = 64'd1442695040888963407;
    localparam logic [63:0] PCG_MUL_X2 = PCG_MUL << 1;
    localparam logic [63:0] PCG_MUL_X3 = PCG_MUL + PCG_MUL_X2;

    localparam int unsigned XSH_SHIFT_A = 18;
    localparam int unsigned XSH_SHIFT_B = 27;
    localparam int unsigned ROT_LSB     = 59;

    typedef enum logic
    {
        OP_MUL,
        OP_MOD
    } iu_op_t;

    typedef struct packed
    {
        logic   start;
        iu_op_t op;
    } iu_req_t;

    typedef struct packed
    {
        logic done;
    } iu_rsp_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_PREP,
        ST_LIMIT,
        ST_DRAW,
        ST_STEP,
        ST_REDUCE,
        ST_OUT
    } gen_state_t;

endpackage

FILE: rtl/pcg32_bounded_int_generator_core.sv
// Returns one uniform signed integer in the inclusive range of each request (bounds in either
// order), drawn from a 64-bit LCG with PCG32 XSH-RR output and rejection sampling. The state
// multiply and both remainders run through one shared iterative unit (radix-4 multiply,
// radix-2 remainder). A request takes a setup step, a limit remainder, a draw and state step
// per draw, a final remainder and an output load; each rejected draw adds another draw and
// state step, and a full 2^32 range skips both remainders. in_ready is high only between
// requests. Writing the 64-bit seed register (byte address 0) reloads the state as seed plus
// the increment; reset acts as a seed of zero.
module pcg32_bounded_int_generator_core
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [pcgbi_pkg::APB_AW-1:0] paddr,
    input  logic [pcgbi_pkg::APB_DW-1:0] pwdata,
    output logic [pcgbi_pkg::APB_DW-1:0] prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] min_value,
    input  logic signed [31:0] max_value,

    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value
);
    import pcgbi_pkg::*;

    gen_state_t        state_reg;
    gen_state_t        state_next;

    logic [63:0]       seed_reg;
    logic [63:0]       lcg_reg;
    logic [63:0]       lcg_next;
    logic [31:0]       lo_reg;
    logic [31:0]       span_reg;
    logic [31:0]       limit_reg;
    logic [31:0]       word_reg;
    logic [31:0]       result_reg;
    logic [31:0]       result_next;
    logic              out_valid_reg;
    logic signed [31:0] out_value_reg;

    logic              in_fire;
    logic              seed_wr;
    logic              bounds_swap;
    logic [31:0]       lo_in;
    logic [31:0]       hi_in;
    logic [31:0]       span_in;
    logic              full_span;
    logic              reject;
    logic              out_load;
    logic [31:0]       xs;
    logic [63:0]       rot_pair;
    logic [31:0]       draw;
    logic [63:0]       inc_base;

    iu_req_t           iu_req;
    iu_rsp_t           iu_rsp;
    logic [63:0]       iu_a;
    logic [31:0]       iu_b;
    logic [63:0]       iu_result;

    pcgbi_iter_unit u_iter
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (iu_req),
        .a      (iu_a),
        .b      (iu_b),
        .rsp    (iu_rsp),
        .result (iu_result)
    );

    assign pready   = 1'b1;
    assign seed_wr  = psel && penable && pwrite && (paddr[3] == REG_SEED);
    assign prdata   = (paddr[3] == REG_SEED) ? seed_reg : '0;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    assign bounds_swap = min_value > max_value;
    assign lo_in       = bounds_swap ? max_value : min_value;
    assign hi_in       = bounds_swap ? min_value : max_value;
    assign span_in     = hi_in - lo_in + 32'd1;

    assign full_span = (span_reg == '0);
    assign reject    = !full_span && (word_reg >= limit_reg);
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    // XSH-RR output of the current state
    assign xs       = 32'((lcg_reg ^ (lcg_reg >> XSH_SHIFT_A)) >> XSH_SHIFT_B);
    assign rot_pair = {xs, xs} >> lcg_reg[63:ROT_LSB];
    assign draw     = rot_pair[31:0];

    // one adder for both seed reload and state step
    assign inc_base = seed_wr ? pwdata : iu_result;
    assign lcg_next = inc_base + PCG_INC;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                    state_next = ST_PREP;
            ST_PREP:
                state_next = full_span ? ST_DRAW : ST_LIMIT;
            ST_LIMIT:
                if (iu_rsp.done)
                    state_next = ST_DRAW;
            ST_DRAW:
                state_next = ST_STEP;
            ST_STEP:
                if (iu_rsp.done)
                begin
                    priority if (full_span)
                        state_next = ST_OUT;
                    else if (reject)
                        state_next = ST_DRAW;
                    else
                        state_next = ST_REDUCE;
                end
            ST_REDUCE:
                if (iu_rsp.done)
                    state_next = ST_OUT;
            ST_OUT:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        iu_req.start = 1'b0;
        iu_req.op    = OP_MOD;
        iu_a         = {32'd0, word_reg};
        iu_b         = span_reg;
        unique case (state_reg)
            ST_PREP:
            begin
                iu_req.start = !full_span;
                iu_a         = {32'd0, 32'hFFFF_FFFF};
            end
            ST_DRAW:
            begin
                iu_req.start = 1'b1;
                iu_req.op    = OP_MUL;
                iu_a         = lcg_reg;
            end
            ST_STEP:
                iu_req.start = iu_rsp.done && !full_span && !reject;
            default:
                iu_req.start = 1'b0;
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_STEP)
            result_next = lo_reg + word_reg;
        else
            result_next = lo_reg + iu_result[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_reg      <= '0;
            lcg_reg       <= PCG_INC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (seed_wr)
            begin
                seed_reg <= pwdata;
                lcg_reg  <= lcg_next;
            end
            else if ((state_reg == ST_STEP) && iu_rsp.done)
                lcg_reg <= lcg_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            lo_reg   <= lo_in;
            span_reg <= span_in;
        end
        if ((state_reg == ST_LIMIT) && iu_rsp.done)
            limit_reg <= ~iu_result[31:0];
        if (state_reg == ST_DRAW)
            word_reg <= draw;
        if (((state_reg == ST_STEP) && full_span || (state_reg == ST_REDUCE)) && iu_rsp.done)
            result_reg <= result_next;
        if (out_load)
            out_value_reg <= result_reg;
    end

    assign out_valid = out_valid_reg;
    assign value     = out_value_reg;

    a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_PREP))
        else $error("accepted request did not start setup");

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        iu_rsp.done |-> (state_reg == ST_LIMIT || state_reg == ST_STEP
                         || state_reg == ST_REDUCE))
        else $error("iterative unit finished while sequencer was not waiting");

    a_reduce_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REDUCE) |-> !full_span)
        else $error("remainder started for a full range");

    a_load_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (state_reg == ST_IDLE) && out_valid_reg)
        else $error("result load did not return to idle");

endmodule

FILE: rtl/pcgbi_iter_unit.sv
module pcgbi_iter_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  pcgbi_pkg::iu_req_t req,
    input  logic [63:0]       a,
    input  logic [31:0]       b,
    output pcgbi_pkg::iu_rsp_t rsp,
    output logic [63:0]       result
);
    import pcgbi_pkg::*;

    // OP_MUL: a * PCG_MUL mod 2^64, two multiplier bits per cycle (Horner, MSB first)
    // OP_MOD: a[31:0] mod b, restoring, one dividend bit per cycle
    localparam int unsigned STEPS = 32;

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    iu_op_t            op_reg;
    logic [63:0]       acc_reg;
    logic [63:0]       acc_next;
    logic [63:0]       sh_reg;
    logic [31:0]       b_reg;

    logic [32:0]       trial;
    logic [63:0]       add_x;
    logic [63:0]       add_y;
    logic              add_cin;
    logic [64:0]       add_sum;

    always_comb
    begin
        trial = {acc_reg[31:0], sh_reg[63]};
        if (op_reg == OP_MUL)
        begin
            add_x   = acc_reg << 2;
            add_cin = 1'b0;
            unique case (sh_reg[63:62])
                2'd0:    add_y = '0;
                2'd1:    add_y = PCG_MUL;
                2'd2:    add_y = PCG_MUL_X2;
                default: add_y = PCG_MUL_X3;
            endcase
        end
        else
        begin
            add_x   = {31'd0, trial};
            add_y   = ~{32'd0, b_reg};
            add_cin = 1'b1;
        end
        add_sum = {1'b0, add_x} + {1'b0, add_y} + {64'd0, add_cin};

        if (op_reg == OP_MUL)
            acc_next = add_sum[63:0];
        else if (add_sum[64])
            acc_next = {32'd0, add_sum[31:0]};
        else
            acc_next = {32'd0, trial[31:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg  <= req.op;
            acc_reg <= '0;
            b_reg   <= b;
            if (req.op == OP_MUL)
                sh_reg <= a;
            else
                sh_reg <= {a[31:0], 32'd0};
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            if (op_reg == OP_MUL)
                sh_reg <= sh_reg << 2;
            else
                sh_reg <= sh_reg << 1;
        end
    end

    assign rsp.done = done_reg;
    assign result   = acc_reg;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import pcgbi_pkg::*;

    localparam logic signed [31:0] S32_MIN     = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX     = 32'sh7FFF_FFFF;
    localparam logic [3:0]         SEED_ADDR   = {REG_SEED, 3'b000};
    localparam logic [3:0]         UNUSED_ADDR = {~REG_SEED, 3'b000};
    localparam int unsigned        PHASE_REQS  = 100;
    localparam int unsigned        NUM_PHASES  = 7;
    localparam int unsigned        NUM_DIRECTED = 20;
    localparam int unsigned        HOLD_CYCLES = 400;
    localparam int unsigned        DRAIN_CYCLES = 120;
    localparam longint unsigned    CYCLE_LIMIT = 1_000_000;

    typedef struct packed
    {
        logic [31:0] bound_a;
        logic [31:0] bound_b;
        logic        fixed;
        logic [31:0] want;
    } directed_req_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] value;

    logic [63:0]        pcg_state;
    logic [63:0]        seed_reg;
    logic [31:0]        pending_values [$];
    int unsigned        mismatches;
    longint unsigned    cycles;
    bit                 send_idle_en;
    bit                 recv_idle_en;
    bit                 hold_output;
    directed_req_t      directed_reqs [NUM_DIRECTED];

    pcg32_bounded_int_generator_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .min_value (min_value),
        .max_value (max_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [31:0] next_pcg_word();
        logic [63:0] old;
        logic [31:0] xs;
        logic [63:0] doubled;
        old       = pcg_state;
        pcg_state = old * PCG_MUL + PCG_INC;
        xs        = 32'((old ^ (old >> XSH_SHIFT_A)) >> XSH_SHIFT_B);
        doubled   = {xs, xs} >> old[63:ROT_LSB];
        return doubled[31:0];
    endfunction

    function automatic logic [31:0] predict_value(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] span;
        logic [31:0] limit;
        logic [31:0] word;
        if ($signed(a) > $signed(b))
        begin
            lo = b;
            hi = a;
        end
        else
        begin
            lo = a;
            hi = b;
        end
        span = hi - lo + 32'd1;
        if (span == 32'd0)
            return lo + next_pcg_word();
        limit = 32'hFFFF_FFFF - (32'hFFFF_FFFF % span);
        do
            word = next_pcg_word();
        while (word >= limit);
        return lo + (word % span);
    endfunction

    function automatic int unsigned draw_gap(input bit en);
        return en ? $urandom_range(0, 13) : 0;
    endfunction

    // caller sits just after a falling edge; returns just after a falling edge
    task automatic send_request(input logic [31:0] a, input logic [31:0] b,
                                input logic fixed, input logic [31:0] want);
        int unsigned gap;
        logic [31:0] predicted;
        gap = draw_gap(send_idle_en);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        min_value <= a;
        max_value <= b;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = predict_value(a, b);
        pending_values.push_back(fixed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_seed_readback();
        logic [63:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= SEED_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        if (rd !== seed_reg)
        begin
            $display("%0t: seed readback mismatch: expected %h, actual %h", $time, seed_reg, rd);
            mismatches++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_seed(input logic [63:0] s);
        write_reg(SEED_ADDR, s);
        seed_reg  = s;
        pcg_state = s + PCG_INC;
        check_seed_readback();
    endtask

    task automatic random_bounds(output logic [31:0] a, output logic [31:0] b);
        logic [31:0] edges [4];
        logic [31:0] t;
        edges = '{S32_MIN, S32_MAX, 32'd0, 32'hFFFF_FFFF};
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                a = $urandom;
                b = $urandom;
            end
            4, 5, 6:
            begin
                a = $urandom;
                b = a + 32'($urandom_range(0, 15));
            end
            7:
            begin
                a = $urandom;
                b = a;
            end
            8:
            begin
                a = edges[$urandom_range(0, 3)];
                b = $urandom_range(0, 1) ? edges[$urandom_range(0, 3)] : $urandom;
            end
            default:
            begin
                a = $urandom;
                b = a - 32'($urandom_range(1, 1000));
            end
        endcase
        if ($urandom_range(0, 1) == 1)
        begin
            t = a;
            a = b;
            b = t;
        end
    endtask

    task automatic drain_results();
        while (pending_values.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // result side
    initial
    begin
        int unsigned stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_output)
            begin
                stall       = HOLD_CYCLES;
                hold_output = 1'b0;
            end
            else
                stall = draw_gap(recv_idle_en);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_values.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h", $time, value);
                mismatches++;
            end
            else if (value !== pending_values[0])
            begin
                $display("%0t: value mismatch: expected %h, actual %h",
                         $time, pending_values[0], value);
                mismatches++;
                void'(pending_values.pop_front());
            end
            else
                void'(pending_values.pop_front());
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("pcg32_bounded_int_generator_core verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] phase_seeds [NUM_PHASES];
        logic [31:0] a;
        logic [31:0] b;
        mismatches   = 0;
        cycles       = 0;
        hold_output  = 1'b0;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        min_value    = '0;
        max_value    = '0;
        seed_reg     = 64'd0;
        pcg_state    = PCG_INC;

        directed_reqs = '{
            '{32'd0,          32'd0,          1'b1, 32'd0},
            '{S32_MIN,        S32_MIN,        1'b1, S32_MIN},
            '{S32_MAX,        S32_MAX,        1'b1, S32_MAX},
            '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF},
            '{S32_MIN,        S32_MAX,        1'b0, 32'd0},
            '{S32_MAX,        S32_MIN,        1'b0, 32'd0},
            '{32'd0,          32'd1,          1'b0, 32'd0},
            '{32'd1,          32'd0,          1'b0, 32'd0},
            '{S32_MIN,        32'd0,          1'b0, 32'd0},
            '{32'd0,          S32_MAX,        1'b0, 32'd0},
            '{S32_MIN,        S32_MAX - 1,    1'b0, 32'd0},
            '{S32_MIN + 1,    S32_MAX,        1'b0, 32'd0},
            '{32'hFFFF_FFFF,  32'd0,          1'b0, 32'd0},
            '{32'd100,        -32'sd100,      1'b0, 32'd0},
            '{S32_MIN,        32'hFFFF_FFFF,  1'b0, 32'd0},
            '{32'hFFFF_FFFF,  S32_MIN,        1'b0, 32'd0},
            '{32'h5555_5555,  32'hAAAA_AAAA,  1'b0, 32'd0},
            '{S32_MAX,        32'hFFFF_FFFF,  1'b0, 32'd0},
            '{32'd0,          32'd2,          1'b0, 32'd0},
            '{32'd7,          32'd7,          1'b1, 32'd7}
        };

        // phase seeds: zero, all ones, state of zero, top bit only, then random
        phase_seeds[0] = 64'd0;
        phase_seeds[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        phase_seeds[2] = 64'd0 - PCG_INC;
        phase_seeds[3] = 64'h8000_0000_0000_0000;
        for (int unsigned k = 4; k < NUM_PHASES; k++)
            phase_seeds[k] = {$urandom, $urandom};

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset state, no seed written yet
        foreach (directed_reqs[k])
            send_request(directed_reqs[k].bound_a, directed_reqs[k].bound_b,
                         directed_reqs[k].fixed, directed_reqs[k].want);
        in_valid <= 1'b0;
        drain_results();
        check_seed_readback();

        for (int unsigned p = 0; p < NUM_PHASES; p++)
        begin
            load_seed(phase_seeds[p]);
            if (p == 1)
            begin
                // unmapped register: no effect on seed or state
                write_reg(UNUSED_ADDR, {$urandom, $urandom});
                check_seed_readback();
            end
            send_idle_en = (p % 3) != 1;
            recv_idle_en = (p % 3) != 2;
            if (p == 3)
                hold_output = 1'b1;
            for (int unsigned n = 0; n < PHASE_REQS; n++)
            begin
                random_bounds(a, b);
                send_request(a, b, 1'b0, 32'd0);
            end
            in_valid <= 1'b0;
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending_values.size() == 0)
            $display("pcg32_bounded_int_generator_core verification clean");
        else
            $display("pcg32_bounded_int_generator_core verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/pcgbi_pkg.sv
rtl/pcgbi_iter_unit.sv
rtl/pcg32_bounded_int_generator_core.sv
verif/tb.sv
